[rtl/acs_pkg.sv]
// ----------------------------------------------------------------------------
// acs_pkg
// Shared types and constants of the angle compare event scheduler.
// ----------------------------------------------------------------------------
package acs_pkg;

   // table size and derived widths
   localparam int SLOT_COUNT = 8;
   localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CNT_W      = SLOT_W + 1;

   // position layout: revolutions in the upper half, angle in the lower half
   localparam int POS_W   = 32;
   localparam int ANGLE_W = 16;
   localparam int REV_W   = POS_W - ANGLE_W;
   localparam int TAG_W   = 8;

   localparam logic [POS_W-1:0] PERIOD_STEP_RESET = 32'h0001_0000;

   // operation codes
   localparam logic [2:0] OP_REG_PERIODIC   = 3'd0;
   localparam logic [2:0] OP_REG_ONESHOT    = 3'd1;
   localparam logic [2:0] OP_COMPARE_EVENT  = 3'd2;
   localparam logic [2:0] OP_CLEAR_ONESHOT  = 3'd3;
   localparam logic [2:0] OP_CLEAR_PERIODIC = 3'd4;

   // entry kinds
   typedef enum logic [1:0] {
      KIND_FREE     = 2'd0,
      KIND_ONESHOT  = 2'd1,
      KIND_PERIODIC = 2'd2
   } kind_type;

   // input item
   typedef struct packed {
      logic [2:0]       operation;
      logic [POS_W-1:0] current_position;
      logic [POS_W-1:0] target_position;
      logic [TAG_W-1:0] event_tag;
   } req_type;

   // result item
   typedef struct packed {
      logic             accepted;
      logic [2:0]       slot_used;
      logic             fired;
      logic [TAG_W-1:0] fired_tag;
      logic             compare_set;
      logic [POS_W-1:0] compare_position;
   } rsp_type;

   // one stored entry
   typedef struct packed {
      logic [POS_W-1:0] position;
      logic [TAG_W-1:0] tag;
   } entry_type;

endpackage

[rtl/acs_entry_ram.sv]
// ----------------------------------------------------------------------------
// acs_entry_ram
// Simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module acs_entry_ram #(
   parameter int DEPTH = 8,
   parameter int WIDTH = 40
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic                                         rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/angle_compare_event_scheduler.sv]
// ----------------------------------------------------------------------------
// angle_compare_event_scheduler
// Table of compare entries against an encoder position, with a serial
// rescan for the earliest active entry after each compare event.
// ----------------------------------------------------------------------------
//
//   channel | ports                              | direction
//   --------+------------------------------------+-----------
//   req     | req_valid, req_stall, req_item     | in
//   rsp     | rsp_valid, rsp_stall, rsp_item     | out
//   csr     | csr_valid, csr_ready, csr_data     | in
//
// registration, clear and unknown items: pass from idle through exec and done to the result register
// compare event: also passes through the scan state, a one-entry-per-cycle
// scan through the read port of the entry RAM
// one item is in flight at a time; a new item is taken while a result waits
// synchronous active-high reset frees all slots, current slot = last slot
// a stalled result holds the block in its final state until it is taken
// ----------------------------------------------------------------------------
module angle_compare_event_scheduler (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  acs_pkg::req_type req_item,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output acs_pkg::rsp_type rsp_item,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [31:0]      csr_data
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_EXEC = 4'b0010,
      ST_SCAN = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type                             state_ff, state_in;
   acs_pkg::kind_type                     kind_ff [acs_pkg::SLOT_COUNT];
   acs_pkg::kind_type                     kind_in [acs_pkg::SLOT_COUNT];
   logic [acs_pkg::SLOT_W-1:0]            cur_slot_ff, cur_slot_in;
   logic [acs_pkg::POS_W-1:0]             period_step_ff;
   acs_pkg::req_type                      item_ff, item_in;
   acs_pkg::rsp_type                      res_ff, res_in;
   logic                                  rsp_valid_ff, rsp_valid_in;
   acs_pkg::rsp_type                      rsp_item_ff, rsp_item_in;
   logic [acs_pkg::CNT_W-1:0]             issue_cnt_ff, issue_cnt_in;
   logic                                  chk_vld_ff, chk_vld_in;
   logic [acs_pkg::SLOT_W-1:0]            chk_idx_ff, chk_idx_in;
   logic                                  found_ff, found_in;
   logic [acs_pkg::POS_W-1:0]             best_ff, best_in;
   logic [acs_pkg::SLOT_W-1:0]            best_slot_ff, best_slot_in;

   logic                                  req_accept;
   logic                                  free_found;
   logic [acs_pkg::SLOT_W-1:0]            free_idx;
   logic                                  mem_wr_en;
   logic [acs_pkg::SLOT_W-1:0]            mem_wr_addr;
   acs_pkg::entry_type                    mem_wr_data;
   logic                                  mem_rd_en;
   logic [acs_pkg::SLOT_W-1:0]            mem_rd_addr;
   acs_pkg::entry_type                    mem_rd_data;
   logic [acs_pkg::POS_W-1:0]             new_pos;
   logic                                  take;
   logic                                  scan_last;
   logic [acs_pkg::REV_W-1:0]             rev;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_item   = rsp_item_ff;

   // entry position and tag storage
   acs_entry_ram #(
      .DEPTH (acs_pkg::SLOT_COUNT),
      .WIDTH ($bits(acs_pkg::entry_type))
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = acs_pkg::SLOT_COUNT - 1; i >= 0; i--) begin
         if (kind_ff[i] == acs_pkg::KIND_FREE) begin
            free_found = 1'b1;
            free_idx   = acs_pkg::SLOT_W'(i);
         end
      end
   end

   // position of a new entry: periodic placed at next occurrence of the angle
   always_comb begin
      rev = item_ff.current_position[acs_pkg::POS_W-1:acs_pkg::ANGLE_W];
      if (item_ff.current_position[acs_pkg::ANGLE_W-1:0] >
          item_ff.target_position[acs_pkg::ANGLE_W-1:0]) begin
         rev = rev + acs_pkg::REV_W'(1);
      end
      if (item_ff.operation == acs_pkg::OP_REG_PERIODIC) begin
         new_pos = {rev, item_ff.target_position[acs_pkg::ANGLE_W-1:0]};
      end else begin
         new_pos = item_ff.target_position;
      end
      take = (free_idx == cur_slot_ff) || (kind_ff[cur_slot_ff] == acs_pkg::KIND_FREE) ||
             (new_pos < mem_rd_data.position);
   end

   assign scan_last = chk_vld_ff && (chk_idx_ff == acs_pkg::SLOT_W'(acs_pkg::SLOT_COUNT - 1));

   // main control
   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      cur_slot_in  = cur_slot_ff;
      item_in      = item_ff;
      res_in       = res_ff;
      issue_cnt_in = issue_cnt_ff;
      chk_vld_in   = 1'b0;
      chk_idx_in   = chk_idx_ff;
      found_in     = found_ff;
      best_in      = best_ff;
      best_slot_in = best_slot_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = free_idx;
      mem_wr_data  = '{position: new_pos, tag: item_ff.event_tag};
      mem_rd_en    = 1'b0;
      mem_rd_addr  = cur_slot_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_item_in  = rsp_item_ff;

      case (state_ff)
         ST_IDLE: begin
            // take the item and fetch the current entry
            if (req_accept) begin
               item_in   = req_item;
               mem_rd_en = 1'b1;
               state_in  = ST_EXEC;
            end
         end

         ST_EXEC: begin
            res_in   = '0;
            state_in = ST_DONE;
            case (item_ff.operation)
               acs_pkg::OP_REG_PERIODIC, acs_pkg::OP_REG_ONESHOT: begin
                  if (free_found) begin
                     mem_wr_en         = 1'b1;
                     kind_in[free_idx] = (item_ff.operation == acs_pkg::OP_REG_PERIODIC) ?
                                         acs_pkg::KIND_PERIODIC : acs_pkg::KIND_ONESHOT;
                     res_in.accepted   = 1'b1;
                     res_in.slot_used  = 3'(free_idx);
                     if (take) begin
                        cur_slot_in             = free_idx;
                        res_in.compare_set      = 1'b1;
                        res_in.compare_position = new_pos;
                     end
                  end
               end
               acs_pkg::OP_COMPARE_EVENT: begin
                  // fire the current entry, then advance or free it
                  if (kind_ff[cur_slot_ff] != acs_pkg::KIND_FREE) begin
                     res_in.fired     = 1'b1;
                     res_in.fired_tag = mem_rd_data.tag;
                  end
                  if (kind_ff[cur_slot_ff] == acs_pkg::KIND_PERIODIC) begin
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = cur_slot_ff;
                     mem_wr_data = '{position: mem_rd_data.position + period_step_ff,
                                     tag: mem_rd_data.tag};
                  end else begin
                     kind_in[cur_slot_ff] = acs_pkg::KIND_FREE;
                  end
                  issue_cnt_in = '0;
                  found_in     = 1'b0;
                  state_in     = ST_SCAN;
               end
               acs_pkg::OP_CLEAR_ONESHOT: begin
                  for (int i = 0; i < acs_pkg::SLOT_COUNT; i++) begin
                     if (kind_ff[i] == acs_pkg::KIND_ONESHOT) begin
                        kind_in[i] = acs_pkg::KIND_FREE;
                     end
                  end
               end
               acs_pkg::OP_CLEAR_PERIODIC: begin
                  for (int i = 0; i < acs_pkg::SLOT_COUNT; i++) begin
                     if (kind_ff[i] == acs_pkg::KIND_PERIODIC) begin
                        kind_in[i] = acs_pkg::KIND_FREE;
                     end
                  end
               end
               default: begin
               end
            endcase
         end

         ST_SCAN: begin
            // issue one read per cycle
            if (issue_cnt_ff < acs_pkg::CNT_W'(acs_pkg::SLOT_COUNT)) begin
               mem_rd_en    = 1'b1;
               mem_rd_addr  = issue_cnt_ff[acs_pkg::SLOT_W-1:0];
               chk_vld_in   = 1'b1;
               chk_idx_in   = issue_cnt_ff[acs_pkg::SLOT_W-1:0];
               issue_cnt_in = issue_cnt_ff + acs_pkg::CNT_W'(1);
            end
            // keep the smallest active position, lowest slot on ties
            if (chk_vld_ff && (kind_ff[chk_idx_ff] != acs_pkg::KIND_FREE) &&
                (!found_ff || (mem_rd_data.position < best_ff))) begin
               found_in     = 1'b1;
               best_in      = mem_rd_data.position;
               best_slot_in = chk_idx_ff;
            end
            if (scan_last) begin
               if (found_in) begin
                  cur_slot_in = best_slot_in;
               end
               res_in.compare_set      = found_in;
               res_in.compare_position = found_in ? best_in : '0;
               state_in                = ST_DONE;
            end
         end

         ST_DONE: begin
            // hand the result to the output register when it is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_item_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         cur_slot_ff    <= acs_pkg::SLOT_W'(acs_pkg::SLOT_COUNT - 1);
         rsp_valid_ff   <= 1'b0;
         chk_vld_ff     <= 1'b0;
         period_step_ff <= acs_pkg::PERIOD_STEP_RESET;
         for (int i = 0; i < acs_pkg::SLOT_COUNT; i++) begin
            kind_ff[i] <= acs_pkg::KIND_FREE;
         end
      end else begin
         state_ff     <= state_in;
         cur_slot_ff  <= cur_slot_in;
         rsp_valid_ff <= rsp_valid_in;
         chk_vld_ff   <= chk_vld_in;
         kind_ff      <= kind_in;
         if (csr_valid && csr_ready) begin
            period_step_ff <= csr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      res_ff       <= res_in;
      rsp_item_ff  <= rsp_item_in;
      issue_cnt_ff <= issue_cnt_in;
      chk_idx_ff   <= chk_idx_in;
      found_ff     <= found_in;
      best_ff      <= best_in;
      best_slot_ff <= best_slot_in;
   end

`ifndef SYNTH
   // a successful registration leaves its slot active
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC && free_found &&
       (item_ff.operation == acs_pkg::OP_REG_PERIODIC ||
        item_ff.operation == acs_pkg::OP_REG_ONESHOT))
      |=> kind_ff[$past(free_idx)] != acs_pkg::KIND_FREE)
      else $error("registered slot not active");

   // a rescan that found an entry points the current slot at an active entry
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && scan_last && found_in)
      |=> kind_ff[cur_slot_ff] != acs_pkg::KIND_FREE)
      else $error("rescan selected a free slot");

   // results appear only out of the final state
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result without finished item");

   // the scan never issues past the table
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> issue_cnt_ff <= acs_pkg::CNT_W'(acs_pkg::SLOT_COUNT))
      else $error("scan counter overran");
`endif

endmodule
